// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl files, included by dma_channel_arbiter_regs
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dcar_pkg.sv =====
`default_nettype none

package dcar_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 16;
   localparam int CHAN_FIELD_W = 4;

   typedef enum logic [2:0] {
      FUNC_WRITE    = 3'd0,
      FUNC_READ     = 3'd1,
      FUNC_SET_REQ  = 3'd2,
      FUNC_CLR_REQ  = 3'd3,
      FUNC_XFER_END = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      REG_ADDR     = 3'd0,
      REG_BLOCK    = 3'd1,
      REG_CONTROL  = 3'd2,
      REG_TAG_ADDR = 3'd3,
      REG_PRIO_LO  = 3'd4,
      REG_PRIO_HI  = 3'd5,
      REG_IRQ_LO   = 3'd6,
      REG_IRQ_HI   = 3'd7
   } reg_select_type;

   // channels whose request flag is set out of reset (10, 12, 13)
   localparam logic [15:0] RESET_REQUEST = 16'h3400;

   // control register bit positions
   localparam int CTL_DIR_BIT   = 0;
   localparam int CTL_MISC0_BIT = 8;
   localparam int CTL_SYNC_LSB  = 9;
   localparam int CTL_BUSY_BIT  = 24;
   localparam int CTL_MISC1_BIT = 30;

   // interrupt register bit positions
   localparam int IRQ_FORCE_BIT  = 15;
   localparam int IRQ_MASK_LSB   = 16;
   localparam int IRQ_MASTER_BIT = 23;
   localparam int IRQ_STATUS_LSB = 24;
   localparam int IRQ_LINE_BIT   = 31;
   localparam int IRQ_BITS       = 7;

   typedef struct packed {
      logic                    valid;
      logic [CHAN_FIELD_W-1:0] index;
   } arb_result_type;

endpackage

`default_nettype wire

// ===== hdl/dcar_arbiter.sv =====
`default_nettype none

module dcar_arbiter import dcar_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  wire logic [NUM_CHANNELS-1:0] eligible,
   output arb_result_type               grant
);

   // fixed priority, highest index wins
   always_comb begin
      grant = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (eligible[c]) begin
            grant.valid = 1'b1;
            grant.index = CHAN_FIELD_W'(c);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dma_channel_arbiter_regs.sv =====
// channel   direction  tdata (low bit up)                        tuser (low bit up)
// req_      in         channel[3:0], write_data[35:4], zero pad  func[2:0], reg_select[5:3]
// rsp_      out        read_data[31:0], active_valid[32],        -
//                      active_index[36:33], irq_pulse[37], zero pad
//
// one item per cycle sustained while the result is drained; an accepted item lands in the
// input register, and when it advances the register file is updated and the result is
// captured in the result register, which drives rsp_tvalid
// reset is synchronous and active high and restores the valid flags and register file
// to their documented values at once, no clearing pass; payloads are not reset
// a stalled result holds the pipe; the input register takes an item while it is empty or
// while the result register can drain in the same cycle
`default_nettype none

`include "assert_macros.svh"

module dma_channel_arbiter_regs import dcar_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // channel, write_data, pad
   input  wire logic [5:0]  req_tuser,  // func, reg_select
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // read_data, active_valid, active_index, irq_pulse, pad
);

   localparam int ChanBits = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // input register
   logic                    s1_valid_ff, s1_valid_in;
   logic [2:0]              s1_func_ff;
   logic [CHAN_FIELD_W-1:0] s1_channel_ff;
   logic [2:0]              s1_sel_ff;
   logic [31:0]             s1_wdata_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_read_data_ff, rsp_read_data_in;
   logic                    rsp_active_valid_ff;
   logic [CHAN_FIELD_W-1:0] rsp_active_index_ff;
   logic                    rsp_irq_pulse_ff, rsp_irq_pulse_in;

   // per-channel register file
   logic [31:0] addr_ff     [NUM_CHANNELS], addr_in     [NUM_CHANNELS];
   logic [15:0] size_ff     [NUM_CHANNELS], size_in     [NUM_CHANNELS];
   logic [15:0] count_ff    [NUM_CHANNELS], count_in    [NUM_CHANNELS];
   logic [1:0]  sync_ff     [NUM_CHANNELS], sync_in     [NUM_CHANNELS];
   logic [1:0]  misc_ff     [NUM_CHANNELS], misc_in     [NUM_CHANNELS];
   logic [31:0] tag_addr_ff [NUM_CHANNELS], tag_addr_in [NUM_CHANNELS];
   logic [2:0]  prio_ff     [NUM_CHANNELS], prio_in     [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] dir_ff, dir_in;
   logic [NUM_CHANNELS-1:0] busy_ff, busy_in;
   logic [NUM_CHANNELS-1:0] request_ff, request_in;
   logic [NUM_CHANNELS-1:0] enable_ff, enable_in;

   // interrupt halves
   logic                force_ff  [2], force_in  [2];
   logic                master_ff [2], master_in [2];
   logic [IRQ_BITS-1:0] mask_ff   [2], mask_in   [2];
   logic [IRQ_BITS-1:0] status_ff [2], status_in [2];

   logic                advance;
   logic                chan_ok;
   logic [ChanBits-1:0] ci;
   logic                half;
   logic [2:0]          bit_sel;
   logic [7:0]          mask_ext;
   arb_result_type      grant;

   // handshake: drain the input register whenever the result slot is free
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = req_tvalid ? 1'b1 : (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_irq_pulse_ff, rsp_active_index_ff,
                        rsp_active_valid_ff, rsp_read_data_ff};

   assign chan_ok  = {1'b0, s1_channel_ff} < (CHAN_FIELD_W + 1)'(NUM_CHANNELS);
   assign ci       = s1_channel_ff[ChanBits-1:0];
   assign bit_sel  = s1_channel_ff[2:0];
   assign mask_ext = {1'b0, mask_ff[s1_channel_ff[3]]};
   assign half     = s1_sel_ff[0];

   // register file update and read for the item in the input register
   always_comb begin
      addr_in          = addr_ff;
      size_in          = size_ff;
      count_in         = count_ff;
      sync_in          = sync_ff;
      misc_in          = misc_ff;
      tag_addr_in      = tag_addr_ff;
      prio_in          = prio_ff;
      dir_in           = dir_ff;
      busy_in          = busy_ff;
      request_in       = request_ff;
      enable_in        = enable_ff;
      force_in         = force_ff;
      master_in        = master_ff;
      mask_in          = mask_ff;
      status_in        = status_ff;
      rsp_read_data_in = '0;
      rsp_irq_pulse_in = 1'b0;

      case (func_type'(s1_func_ff))
         FUNC_WRITE: begin
            case (reg_select_type'(s1_sel_ff))
               REG_ADDR: begin
                  if (chan_ok) addr_in[ci] = s1_wdata_ff;
               end
               REG_BLOCK: begin
                  if (chan_ok) begin
                     size_in[ci]  = s1_wdata_ff[15:0];
                     count_in[ci] = s1_wdata_ff[31:16];
                  end
               end
               REG_CONTROL: begin
                  if (chan_ok) begin
                     dir_in[ci]  = s1_wdata_ff[CTL_DIR_BIT];
                     sync_in[ci] = s1_wdata_ff[CTL_SYNC_LSB +: 2];
                     busy_in[ci] = s1_wdata_ff[CTL_BUSY_BIT];
                     misc_in[ci] = {s1_wdata_ff[CTL_MISC1_BIT], s1_wdata_ff[CTL_MISC0_BIT]};
                  end
               end
               REG_TAG_ADDR: begin
                  if (chan_ok) tag_addr_in[ci] = s1_wdata_ff;
               end
               REG_PRIO_LO, REG_PRIO_HI: begin
                  // one nibble per channel of the selected half
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if ((c >= 8) == half) begin
                        prio_in[c]   = s1_wdata_ff[(c % 8) * 4 +: 3];
                        enable_in[c] = s1_wdata_ff[(c % 8) * 4 + 3];
                     end
                  end
               end
               REG_IRQ_LO, REG_IRQ_HI: begin
                  force_in[half]   = s1_wdata_ff[IRQ_FORCE_BIT];
                  mask_in[half]    = s1_wdata_ff[IRQ_MASK_LSB +: IRQ_BITS];
                  master_in[half]  = s1_wdata_ff[IRQ_MASTER_BIT];
                  // write one to clear
                  status_in[half]  = status_ff[half] & ~s1_wdata_ff[IRQ_STATUS_LSB +: IRQ_BITS];
                  rsp_irq_pulse_in = s1_wdata_ff[IRQ_FORCE_BIT];
               end
               default: begin
               end
            endcase
         end
         FUNC_READ: begin
            case (reg_select_type'(s1_sel_ff))
               REG_ADDR: begin
                  if (chan_ok) rsp_read_data_in = addr_ff[ci];
               end
               REG_BLOCK: begin
                  if (chan_ok) rsp_read_data_in = {count_ff[ci], size_ff[ci]};
               end
               REG_CONTROL: begin
                  if (chan_ok) begin
                     rsp_read_data_in[CTL_DIR_BIT]       = dir_ff[ci];
                     rsp_read_data_in[CTL_MISC0_BIT]     = misc_ff[ci][0];
                     rsp_read_data_in[CTL_SYNC_LSB +: 2] = sync_ff[ci];
                     rsp_read_data_in[CTL_BUSY_BIT]      = busy_ff[ci];
                     rsp_read_data_in[CTL_MISC1_BIT]     = misc_ff[ci][1];
                  end
               end
               REG_TAG_ADDR: begin
                  if (chan_ok) rsp_read_data_in = tag_addr_ff[ci];
               end
               REG_PRIO_LO, REG_PRIO_HI: begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if ((c >= 8) == half) begin
                        rsp_read_data_in[(c % 8) * 4 +: 4] = {enable_ff[c], prio_ff[c]};
                     end
                  end
               end
               REG_IRQ_LO, REG_IRQ_HI: begin
                  rsp_read_data_in[IRQ_FORCE_BIT]               = force_ff[half];
                  rsp_read_data_in[IRQ_MASK_LSB +: IRQ_BITS]    = mask_ff[half];
                  rsp_read_data_in[IRQ_MASTER_BIT]              = master_ff[half];
                  rsp_read_data_in[IRQ_STATUS_LSB +: IRQ_BITS]  = status_ff[half];
                  rsp_read_data_in[IRQ_LINE_BIT] =
                     master_ff[half] && |(mask_ff[half] & status_ff[half]);
               end
               default: begin
               end
            endcase
         end
         FUNC_SET_REQ: begin
            if (chan_ok) request_in[ci] = 1'b1;
         end
         FUNC_CLR_REQ: begin
            if (chan_ok) request_in[ci] = 1'b0;
         end
         FUNC_XFER_END: begin
            if (chan_ok) begin
               busy_in[ci] = 1'b0;
               // the top channel of each half has no mask bit
               if (mask_ext[bit_sel]) begin
                  status_in[s1_channel_ff[3]][bit_sel] = 1'b1;
                  rsp_irq_pulse_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // grant reflects the state after this item
   dcar_arbiter #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_arbiter (
      .eligible(request_in & busy_in),
      .grant   (grant)
   );

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_func_ff    <= req_tuser[2:0];
         s1_sel_ff     <= req_tuser[5:3];
         s1_channel_ff <= req_tdata[3:0];
         s1_wdata_ff   <= req_tdata[35:4];
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_data_ff    <= rsp_read_data_in;
         rsp_active_valid_ff <= grant.valid;
         rsp_active_index_ff <= grant.index;
         rsp_irq_pulse_ff    <= rsp_irq_pulse_in;
      end
   end

   // register file, written once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            addr_ff[c]     <= '0;
            size_ff[c]     <= '0;
            count_ff[c]    <= '0;
            sync_ff[c]     <= '0;
            misc_ff[c]     <= '0;
            tag_addr_ff[c] <= '0;
            prio_ff[c]     <= 3'h7;
         end
         dir_ff     <= '0;
         busy_ff    <= '0;
         request_ff <= RESET_REQUEST[NUM_CHANNELS-1:0];
         enable_ff  <= '0;
         for (int h = 0; h < 2; h++) begin
            force_ff[h]  <= 1'b0;
            master_ff[h] <= 1'b0;
            mask_ff[h]   <= '0;
            status_ff[h] <= '0;
         end
      end else if (advance) begin
         addr_ff     <= addr_in;
         size_ff     <= size_in;
         count_ff    <= count_in;
         sync_ff     <= sync_in;
         misc_ff     <= misc_in;
         tag_addr_ff <= tag_addr_in;
         prio_ff     <= prio_in;
         dir_ff      <= dir_in;
         busy_ff     <= busy_in;
         request_ff  <= request_in;
         enable_ff   <= enable_in;
         force_ff    <= force_in;
         master_ff   <= master_in;
         mask_ff     <= mask_in;
         status_ff   <= status_in;
      end
   end

   // only reads return data
   `ASSERT_NEXT(a_rdata_zero, clock, reset, advance && s1_func_ff != FUNC_READ,
      rsp_read_data_ff == '0, "read_data nonzero on a non-read item")

   // interrupt only from an interrupt register write or a transfer end
   `ASSERT_NEXT(a_irq_source, clock, reset,
      advance && s1_func_ff != FUNC_WRITE && s1_func_ff != FUNC_XFER_END,
      !rsp_irq_pulse_ff, "irq pulse from an item that cannot raise it")

   // granted channel is requesting and busy in the updated state
   `ASSERT_NEXT(a_grant_eligible, clock, reset, advance,
      !rsp_active_valid_ff || (busy_ff[rsp_active_index_ff[ChanBits-1:0]] &&
      request_ff[rsp_active_index_ff[ChanBits-1:0]]), "granted channel not eligible")

   // no grant reports index zero
   `ASSERT_SAME(a_idle_index, clock, reset, rsp_valid_ff && !rsp_active_valid_ff,
      rsp_active_index_ff == '0, "index nonzero without a grant")

endmodule

`default_nettype wire
